// ===== sv/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // most result beats one input byte can cause
    localparam int MAX_RES        = 4;
    // default depth of the result buffer (power of two, at least MAX_RES)
    localparam int FIFO_DEPTH_DEF = 8;

    // characters the decoder tests for
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;

    // surrogate tags in the top six bits of a code unit
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX,
        MODE_LOW_BS,
        MODE_LOW_U
    } mode_t;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_END,
        ST_NO_OPEN,
        ST_NO_CLOSE,
        ST_BAD_ESC,
        ST_BAD_HEX,
        ST_BAD_SURR,
        ST_CTRL
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an accepted input beat passes the input stage register, then the result buffer, before its first result beat shows
// throughput: one input byte per cycle; results (up to four) leave one per out_ready cycle
// input stalls only while the result buffer holds more than FIFO_DEPTH - 4 beats
// reset (rst_n low, asynchronous): decoder back to idle, input stage and result buffer empty

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [7:0] v;
        v = 8'h00;
        if (ch inside {[8'h30:8'h39]})
        begin
            v = ch - 8'h30;
            return {1'b1, v[3:0]};
        end
        else if (ch inside {[8'h41:8'h46]})
        begin
            v = ch - 8'h37;
            return {1'b1, v[3:0]};
        end
        else if (ch inside {[8'h61:8'h66]})
        begin
            v = ch - 8'h57;
            return {1'b1, v[3:0]};
        end
        return 5'b0_0000;
    endfunction

    // simple escape map: {valid, byte}
    function automatic logic [8:0] esc_map(input logic [7:0] ch);
        logic [8:0] r;
        case (ch)
            CHAR_QUOTE:  r = {1'b1, CHAR_QUOTE};
            CHAR_BSLASH: r = {1'b1, CHAR_BSLASH};
            CHAR_SLASH:  r = {1'b1, CHAR_SLASH};
            CHAR_B:      r = {1'b1, 8'h08};
            CHAR_F:      r = {1'b1, 8'h0C};
            CHAR_N:      r = {1'b1, 8'h0A};
            CHAR_R:      r = {1'b1, 8'h0D};
            CHAR_T:      r = {1'b1, 8'h09};
            default:     r = 9'h000;
        endcase
        return r;
    endfunction

    // input stage
    logic     s1_valid_reg;
    in_item_t s1_data_reg;
    logic     s1_fire;

    // decoder state
    mode_t       mode_reg, mode_next;
    logic [11:0] hex_accum_reg, hex_accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [9:0]  high_part_reg, high_part_next;
    logic        in_low_escape_reg, in_low_escape_next;

    // result buffer
    out_item_t        fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;
    logic [2:0]       push_cnt;

    // shared decode of the staged byte
    logic [7:0]  c;
    logic        eoi;
    logic [4:0]  hex_dec;
    logic [8:0]  esc_dec;
    logic [15:0] hex_word;
    logic        hex_ok, esc_ok, is_high, is_low, byte_bad_ctrl;
    logic [20:0] surr_cp;

    assign c             = s1_data_reg.in_byte;
    assign eoi           = s1_data_reg.end_of_input;
    assign hex_dec       = hex_decode(c);
    assign esc_dec       = esc_map(c);
    assign hex_ok        = hex_dec[4];
    assign esc_ok        = esc_dec[8];
    assign hex_word      = {hex_accum_reg, hex_dec[3:0]};
    assign is_high       = (hex_word[15:10] == SURR_HIGH_TAG);
    assign is_low        = (hex_word[15:10] == SURR_LOW_TAG);
    assign surr_cp       = {1'b0, high_part_reg, hex_word[9:0]} + SUPP_BASE;
    assign byte_bad_ctrl = (c < CTRL_LIMIT);

    // input handshake: stage advances when the buffer has room for a full burst
    assign s1_fire  = s1_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - MAX_RES));
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
    end

    // next decoder state
    always_comb
    begin
        mode_next          = mode_reg;
        hex_accum_next     = hex_accum_reg;
        hex_count_next     = hex_count_reg;
        high_part_next     = high_part_reg;
        in_low_escape_next = in_low_escape_reg;
        case (mode_reg)
            MODE_BODY:
            begin
                if (eoi || c == CHAR_QUOTE || (c != CHAR_BSLASH && byte_bad_ctrl))
                    mode_next = MODE_IDLE;
                else if (c == CHAR_BSLASH)
                    mode_next = MODE_ESC;
            end
            MODE_ESC:
            begin
                if (!eoi && esc_ok)
                    mode_next = MODE_BODY;
                else if (!eoi && c == CHAR_U)
                begin
                    mode_next          = MODE_HEX;
                    hex_accum_next     = '0;
                    hex_count_next     = '0;
                    in_low_escape_next = 1'b0;
                end
                else
                    mode_next = MODE_IDLE;
            end
            MODE_HEX:
            begin
                if (eoi || !hex_ok)
                    mode_next = MODE_IDLE;
                else if (hex_count_reg != 2'd3)
                begin
                    hex_accum_next = hex_word[11:0];
                    hex_count_next = hex_count_reg + 2'd1;
                end
                else
                begin
                    hex_accum_next = '0;
                    hex_count_next = '0;
                    if (in_low_escape_reg)
                    begin
                        mode_next = is_low ? MODE_BODY : MODE_IDLE;
                        in_low_escape_next = 1'b0;
                        high_part_next     = '0;
                    end
                    else if (is_high)
                    begin
                        high_part_next = hex_word[9:0];
                        mode_next      = MODE_LOW_BS;
                    end
                    else
                        mode_next = MODE_BODY;
                end
            end
            MODE_LOW_BS:
            begin
                mode_next = (eoi || c != CHAR_BSLASH) ? MODE_IDLE : MODE_LOW_U;
            end
            MODE_LOW_U:
            begin
                if (eoi || c != CHAR_U)
                    mode_next = MODE_IDLE;
                else
                begin
                    mode_next          = MODE_HEX;
                    hex_accum_next     = '0;
                    hex_count_next     = '0;
                    in_low_escape_next = 1'b1;
                end
            end
            default:
            begin
                mode_next = (eoi || c != CHAR_QUOTE) ? MODE_IDLE : MODE_BODY;
            end
        endcase
        // any error, string end or opening quote leaves everything else cleared
        if (mode_next == MODE_IDLE || (mode_reg == MODE_IDLE && mode_next == MODE_BODY))
        begin
            hex_accum_next     = '0;
            hex_count_next     = '0;
            high_part_next     = '0;
            in_low_escape_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            hex_accum_reg     <= '0;
            hex_count_reg     <= '0;
            high_part_reg     <= '0;
            in_low_escape_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            mode_reg          <= mode_next;
            hex_accum_reg     <= hex_accum_next;
            hex_count_reg     <= hex_count_next;
            high_part_reg     <= high_part_next;
            in_low_escape_reg <= in_low_escape_next;
        end
    end

    // result beats for the staged byte
    out_item_t   res [MAX_RES];
    logic [2:0]  res_cnt;
    logic        is_err, is_data, do_enc;
    status_t     err_st;
    logic [7:0]  data_byte;
    logic [20:0] cp;

    always_comb
    begin
        is_err    = 1'b0;
        err_st    = ST_DATA;
        is_data   = 1'b0;
        data_byte = 8'h00;
        do_enc    = 1'b0;
        cp        = '0;
        case (mode_reg)
            MODE_BODY:
            begin
                if (eoi)
                begin
                    is_err = 1'b1;
                    err_st = ST_NO_CLOSE;
                end
                else if (c == CHAR_QUOTE)
                begin
                    is_err = 1'b1;
                    err_st = ST_END;
                end
                else if (c == CHAR_BSLASH)
                    is_data = 1'b0;
                else if (byte_bad_ctrl)
                begin
                    is_err = 1'b1;
                    err_st = ST_CTRL;
                end
                else
                begin
                    is_data   = 1'b1;
                    data_byte = c;
                end
            end
            MODE_ESC:
            begin
                if (!eoi && esc_ok)
                begin
                    is_data   = 1'b1;
                    data_byte = esc_dec[7:0];
                end
                else if (eoi || c != CHAR_U)
                begin
                    is_err = 1'b1;
                    err_st = ST_BAD_ESC;
                end
            end
            MODE_HEX:
            begin
                if (eoi || !hex_ok)
                begin
                    is_err = 1'b1;
                    err_st = ST_BAD_HEX;
                end
                else if (hex_count_reg == 2'd3)
                begin
                    if (in_low_escape_reg)
                    begin
                        if (!is_low)
                        begin
                            is_err = 1'b1;
                            err_st = ST_BAD_SURR;
                        end
                        else
                        begin
                            do_enc = 1'b1;
                            cp     = surr_cp;
                        end
                    end
                    else if (!is_high)
                    begin
                        do_enc = 1'b1;
                        cp     = {5'b0_0000, hex_word};
                    end
                end
            end
            MODE_LOW_BS:
            begin
                if (eoi || c != CHAR_BSLASH)
                begin
                    is_err = 1'b1;
                    err_st = ST_BAD_SURR;
                end
            end
            MODE_LOW_U:
            begin
                if (eoi || c != CHAR_U)
                begin
                    is_err = 1'b1;
                    err_st = ST_BAD_SURR;
                end
            end
            default:
            begin
                if (eoi || c != CHAR_QUOTE)
                begin
                    is_err = 1'b1;
                    err_st = ST_NO_OPEN;
                end
            end
        endcase
    end

    // assemble beats, utf-8 encoding of a code point
    always_comb
    begin
        for (int k = 0; k < MAX_RES; k++)
            res[k] = '{out_byte: 8'h00, status: ST_DATA, last: 1'b0};
        res_cnt = 3'd0;
        if (is_err)
        begin
            res[0].status = err_st;
            res_cnt       = 3'd1;
        end
        else if (is_data)
        begin
            res[0].out_byte = data_byte;
            res_cnt         = 3'd1;
        end
        else if (do_enc)
        begin
            if (cp[20:7] == '0)
            begin
                res[0].out_byte = cp[7:0];
                res_cnt         = 3'd1;
            end
            else if (cp[20:11] == '0)
            begin
                res[0].out_byte = {3'b110, cp[10:6]};
                res[1].out_byte = {2'b10, cp[5:0]};
                res_cnt         = 3'd2;
            end
            else if (cp[20:16] == '0)
            begin
                res[0].out_byte = {4'b1110, cp[15:12]};
                res[1].out_byte = {2'b10, cp[11:6]};
                res[2].out_byte = {2'b10, cp[5:0]};
                res_cnt         = 3'd3;
            end
            else
            begin
                res[0].out_byte = {5'b11110, cp[20:18]};
                res[1].out_byte = {2'b10, cp[17:12]};
                res[2].out_byte = {2'b10, cp[11:6]};
                res[3].out_byte = {2'b10, cp[5:0]};
                res_cnt         = 3'd4;
            end
        end
        for (int k = 0; k < MAX_RES; k++)
            res[k].last = (res_cnt == 3'(k + 1));
    end

    // result buffer
    assign pop       = out_valid && out_ready;
    assign push_cnt  = s1_fire ? res_cnt : 3'd0;
    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int k = 0; k < MAX_RES; k++)
            begin
                if (res_cnt > 3'(k))
                    fifo_reg[wr_ptr_reg + PTR_W'(k)] <= res[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== sv/jsu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // end and error beats are always the final beat of their byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_DATA |-> out_data.last)
        else $error("end or error beat without last");

    // end and error beats carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_DATA |-> out_data.out_byte == 8'h00)
        else $error("end or error beat with nonzero byte");

    // the rest of a multi-byte burst is already buffered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> out_valid)
        else $error("gap inside a utf-8 burst");

    // an empty result buffer never holds off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty result buffer");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/jsu_decode_checker.sv =====
`timescale 1ns / 1ps

module jsu_decode_checker
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        outstanding
);

    // decoder state, kept apart from the block
    mode_t       mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [9:0]  high_bits;
    logic        low_esc;

    // result beats still owed by the block, oldest first
    out_item_t   decoded_beats[$];
    out_item_t   want;
    int          reported;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        reported    = 0;
    end

    task automatic clear_decoder();
        mode      = MODE_IDLE;
        hex_acc   = '0;
        hex_cnt   = '0;
        high_bits = '0;
        low_esc   = 1'b0;
    endtask

    task automatic owe_beat(input logic [7:0] b, input status_t st, input logic fin);
        decoded_beats.insert(decoded_beats.size(),
                             out_item_t'{out_byte: b, status: st, last: fin});
    endtask

    // error or string end: one beat, then back to idle
    task automatic close_string(input status_t st);
        clear_decoder();
        owe_beat(8'h00, st, 1'b1);
    endtask

    // code point to one..four utf-8 bytes
    task automatic owe_utf8(input logic [20:0] cp);
        logic [7:0] seq[4];
        int         n;
        if (cp <= 21'h7F) begin
            seq[0] = cp[7:0];
            n = 1;
        end
        else if (cp <= 21'h7FF) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            n = 2;
        end
        else if (cp <= 21'hFFFF) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            n = 3;
        end
        else begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int i = 0; i < n; i++)
            owe_beat(seq[i], ST_DATA, i == n - 1);
    endtask

    // bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] t;
        if (c >= "0" && c <= "9")
            t = c - "0";
        else if (c >= "A" && c <= "F")
            t = c - "A" + 8'd10;
        else if (c >= "a" && c <= "f")
            t = c - "a" + 8'd10;
        else
            return 5'h10;
        return {1'b0, t[3:0]};
    endfunction

    // one accepted input byte
    task automatic decode_byte(input in_item_t item);
        logic [7:0]  c;
        logic        eoi;
        logic [4:0]  nib;
        logic [15:0] unit;
        logic [20:0] cp;
        c   = item.in_byte;
        eoi = item.end_of_input;
        case (mode)
            MODE_BODY: begin
                if (eoi)
                    close_string(ST_NO_CLOSE);
                else if (c == CHAR_QUOTE)
                    close_string(ST_END);
                else if (c == CHAR_BSLASH)
                    mode = MODE_ESC;
                else if (c < CTRL_LIMIT)
                    close_string(ST_CTRL);
                else
                    owe_beat(c, ST_DATA, 1'b1);
            end
            MODE_ESC: begin
                if (eoi)
                    close_string(ST_BAD_ESC);
                else begin
                    case (c)
                        CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: begin
                            mode = MODE_BODY;
                            owe_beat(c, ST_DATA, 1'b1);
                        end
                        CHAR_B: begin
                            mode = MODE_BODY;
                            owe_beat(8'h08, ST_DATA, 1'b1);
                        end
                        CHAR_F: begin
                            mode = MODE_BODY;
                            owe_beat(8'h0C, ST_DATA, 1'b1);
                        end
                        CHAR_N: begin
                            mode = MODE_BODY;
                            owe_beat(8'h0A, ST_DATA, 1'b1);
                        end
                        CHAR_R: begin
                            mode = MODE_BODY;
                            owe_beat(8'h0D, ST_DATA, 1'b1);
                        end
                        CHAR_T: begin
                            mode = MODE_BODY;
                            owe_beat(8'h09, ST_DATA, 1'b1);
                        end
                        CHAR_U: begin
                            mode    = MODE_HEX;
                            hex_acc = '0;
                            hex_cnt = '0;
                            low_esc = 1'b0;
                        end
                        default: close_string(ST_BAD_ESC);
                    endcase
                end
            end
            MODE_HEX: begin
                nib = nibble_of(c);
                if (eoi || nib[4])
                    close_string(ST_BAD_HEX);
                else begin
                    unit = {hex_acc[11:0], nib[3:0]};
                    if (hex_cnt != 2'd3) begin
                        hex_acc = unit;
                        hex_cnt = hex_cnt + 2'd1;
                    end
                    else begin
                        hex_acc = '0;
                        hex_cnt = '0;
                        if (low_esc) begin
                            // second half of a pair must be a low surrogate
                            if (unit < 16'hDC00 || unit > 16'hDFFF)
                                close_string(ST_BAD_SURR);
                            else begin
                                cp        = {1'b0, high_bits, unit[9:0]} + 21'h10000;
                                low_esc   = 1'b0;
                                high_bits = '0;
                                mode      = MODE_BODY;
                                owe_utf8(cp);
                            end
                        end
                        else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                            high_bits = unit[9:0];
                            mode      = MODE_LOW_BS;
                        end
                        else begin
                            mode = MODE_BODY;
                            owe_utf8({5'b0, unit});
                        end
                    end
                end
            end
            MODE_LOW_BS: begin
                if (eoi || c != CHAR_BSLASH)
                    close_string(ST_BAD_SURR);
                else
                    mode = MODE_LOW_U;
            end
            MODE_LOW_U: begin
                if (eoi || c != CHAR_U)
                    close_string(ST_BAD_SURR);
                else begin
                    mode    = MODE_HEX;
                    hex_acc = '0;
                    hex_cnt = '0;
                    low_esc = 1'b1;
                end
            end
            default: begin
                if (eoi || c != CHAR_QUOTE)
                    close_string(ST_NO_OPEN);
                else begin
                    clear_decoder();
                    mode = MODE_BODY;
                end
            end
        endcase
    endtask

    // watch both channels, predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_decoder();
            decoded_beats.delete();
            outstanding = 0;
        end
        else begin
            if (in_valid && in_ready)
                decode_byte(in_data);
            if (out_valid && out_ready) begin
                if (decoded_beats.size() == 0) begin
                    fail_count++;
                    if (reported < 10)
                        $display("unexpected result beat: byte %02h status %0d last %b",
                                 out_data.out_byte, out_data.status, out_data.last);
                    reported++;
                end
                else begin
                    want = decoded_beats.pop_front();
                    if (out_data.out_byte !== want.out_byte ||
                        out_data.status !== want.status ||
                        out_data.last !== want.last) begin
                        fail_count++;
                        if (reported < 10)
                            $display({"result mismatch: expected byte %02h status %0d last %b,",
                                      " got byte %02h status %0d last %b"},
                                     want.out_byte, want.status, want.last,
                                     out_data.out_byte, out_data.status, out_data.last);
                        reported++;
                    end
                end
            end
            outstanding = decoded_beats.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import jsu_pkg::*;

    localparam int RANDOM_BYTES = 280;
    localparam int HOLD_CYCLES  = 50;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_item_t  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    out_item_t out_data;
    int        fail_count;
    int        outstanding;

    // stimulus knobs shared with the receiver
    bit        idle_on   = 1'b1;
    bit        hold_req  = 1'b0;
    int        hold_left = 0;

    in_item_t  line_bytes[$];
    int        sent_count = 0;

    json_string_unescape_utf8 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    jsu_decode_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(idle_on && $urandom_range(0, 99) < 13);
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        line_bytes.insert(line_bytes.size(), in_item_t'{in_byte: b, end_of_input: 1'b0});
    endtask

    // input ends here, byte content is don't-care
    task automatic push_eoi();
        line_bytes.insert(line_bytes.size(),
                          in_item_t'{in_byte: 8'($urandom_range(0, 255)),
                                     end_of_input: 1'b1});
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + 8'(n);
        return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    task automatic push_u16(input logic [15:0] v);
        push_byte(CHAR_BSLASH);
        push_byte(CHAR_U);
        push_byte(hex_char(v[15:12]));
        push_byte(hex_char(v[11:8]));
        push_byte(hex_char(v[7:4]));
        push_byte(hex_char(v[3:0]));
    endtask

    // supplementary code point given as its offset above 0x10000
    task automatic push_pair(input logic [19:0] off);
        push_u16({6'b110110, off[19:10]});
        push_u16({6'b110111, off[9:0]});
    endtask

    // one well-formed piece of string content
    task automatic push_piece();
        logic [7:0]  b;
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                b = 8'($urandom_range(32, 255));
                if (b == CHAR_QUOTE || b == CHAR_BSLASH)
                    b = b + 8'd1;
                push_byte(b);
            end
            4: begin
                push_byte(CHAR_BSLASH);
                case ($urandom_range(0, 7))
                    0: push_byte(CHAR_QUOTE);
                    1: push_byte(CHAR_BSLASH);
                    2: push_byte(CHAR_SLASH);
                    3: push_byte(CHAR_B);
                    4: push_byte(CHAR_F);
                    5: push_byte(CHAR_N);
                    6: push_byte(CHAR_R);
                    default: push_byte(CHAR_T);
                endcase
            end
            5: push_u16(16'($urandom_range(0, 16'h7F)));
            6: push_u16(16'($urandom_range(16'h80, 16'h7FF)));
            7: begin
                // a high surrogate here becomes a lone low one
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= 16'hD800 && v <= 16'hDBFF)
                    v = v | 16'h0400;
                push_u16(v);
            end
            8: push_pair(20'($urandom));
            default: begin
                case ($urandom_range(0, 7))
                    0: push_u16(16'h0000);
                    1: push_u16(16'hFFFF);
                    2: push_u16(16'h007F);
                    3: push_u16(16'h0080);
                    4: push_u16(16'h07FF);
                    5: push_u16(16'h0800);
                    6: push_pair(20'h00000);
                    default: push_pair(20'hFFFFF);
                endcase
            end
        endcase
    endtask

    task automatic push_high();
        push_u16({6'b110110, 10'($urandom)});
    endtask

    // random string: mostly well formed, some broken on purpose
    task automatic build_string();
        logic [7:0]  b;
        logic [15:0] v;
        int          flaw;
        line_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_QUOTE)
                b = 8'h00;
            push_byte(b);
        end
        push_byte(CHAR_QUOTE);
        repeat ($urandom_range(0, 8)) push_piece();
        flaw = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 12) : 0;
        case (flaw)
            0: push_byte(CHAR_QUOTE);
            1: push_eoi();
            2: push_byte(8'($urandom_range(0, 31)));
            3: begin
                b = 8'($urandom_range(0, 255));
                if (b == CHAR_QUOTE || b == CHAR_BSLASH || b == CHAR_SLASH ||
                    b == CHAR_B || b == CHAR_F || b == CHAR_N || b == CHAR_R ||
                    b == CHAR_T || b == CHAR_U)
                    b = "a";
                push_byte(CHAR_BSLASH);
                push_byte(b);
            end
            4: begin
                push_byte(CHAR_BSLASH);
                push_eoi();
            end
            5: begin
                b = 8'($urandom_range(0, 255));
                if ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                    (b >= "a" && b <= "f"))
                    b = "g";
                push_byte(CHAR_BSLASH);
                push_byte(CHAR_U);
                repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
                push_byte(b);
            end
            6: begin
                push_byte(CHAR_BSLASH);
                push_byte(CHAR_U);
                repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
                push_eoi();
            end
            7: begin
                b = 8'($urandom_range(32, 255));
                if (b == CHAR_BSLASH)
                    b = "x";
                push_high();
                push_byte(b);
            end
            8: begin
                b = 8'($urandom_range(0, 255));
                if (b == CHAR_U)
                    b = "n";
                push_high();
                push_byte(CHAR_BSLASH);
                push_byte(b);
            end
            9: begin
                v = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'hDBFF))
                                         : 16'($urandom_range(16'hE000, 16'hFFFF));
                push_high();
                push_u16(v);
            end
            10: begin
                push_high();
                push_eoi();
            end
            11: begin
                push_high();
                push_byte(CHAR_BSLASH);
                push_eoi();
            end
            default: begin
                push_high();
                push_byte(CHAR_BSLASH);
                push_byte(CHAR_U);
                repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom)));
                push_eoi();
            end
        endcase
    endtask

    // offer one beat and hold it until taken
    task automatic send_beat(input in_item_t item);
        if (idle_on && $urandom_range(0, 99) < 13) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) begin
            send_beat(line_bytes[i]);
            sent_count++;
        end
    endtask

    // stop offering until every owed result beat has left
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    initial
    begin
        int lines;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no opening quote, control byte, escaped zero, a pair, closing quote
        line_bytes.delete();
        push_byte(8'hFF);
        push_eoi();
        push_byte(CHAR_QUOTE);
        push_byte(8'h00);
        push_byte(CHAR_QUOTE);
        push_u16(16'h0000);
        push_u16(16'hD83D);
        push_u16(16'hDE00);
        push_byte(CHAR_QUOTE);
        send_line();
        drain();

        // random strings
        lines = 0;
        sent_count = 0;
        while (sent_count < RANDOM_BYTES) begin
            idle_on = !(lines >= 6 && lines < 14);
            if (lines == 7)
                hold_req = 1'b1;
            build_string();
            send_line();
            if (lines == 18)
                drain();
            lines++;
        end

        idle_on = 1'b1;
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/jsu_pkg.sv
sv/json_string_unescape_utf8.sv
sv/jsu_checker.sv
tb/jsu_decode_checker.sv
tb/tb_top.sv
